/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl of the cursor linked list
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

/* rtl/core/cll_pkg.sv */
// types and codes of the cursor linked list
// no dependencies; imported by cursor_linked_list
package cll_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [9:0] length;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_INS_FREE,
		S_INS_POP,
		S_WALK,
		S_INS_LINK,
		S_DEL_VIC,
		S_DEL_FREE,
		S_DEL_PUSH,
		S_DONE
	} state_t;

endpackage

/* rtl/core/cursor_linked_list.sv */
// cursor linked list: array-backed singly linked list with its own free chain
// depends on cll_pkg and assert_macros.svh
//
//  channel  | handshake        | payload | notes
//  ---------+------------------+---------+-------------------------------
//  request  | start, busy      | req     | beat taken when start && !busy
//  result   | done             | rsp     | one cycle, cannot be held off
//
// inserts and deletes are paced by the walk, which follows one link per cycle through
// the single read port of the link memory to the predecessor of position;
// failed items skip the walk.
// after reset a clearing pass writes the free chain with busy high.
// busy stays high from acceptance until the cycle after done; results cannot stall.
`include "assert_macros.svh"

module cursor_linked_list import cll_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CMPW = ((AW > 10) ? AW : 10) + 1;
	localparam logic [AW-1:0] HEAD = AW'(DEPTH - 1);
	localparam logic [AW-1:0] FREE = '0;
	localparam logic [AW-1:0] LAST_FREE = AW'(DEPTH - 2);

	logic [AW-1:0] link_mem [DEPTH];
	logic [31:0]   val_mem  [DEPTH];

	state_t state_q, state_d;
	req_t   req_q;
	logic [AW-1:0] count_q;
	logic [AW-1:0] clr_idx_q;
	logic          ok_q;
	logic [AW-1:0] cur_q, slot_q, pred_q, victim_q;
	logic [9:0]    steps_q;
	logic [AW-1:0] rdata_q;
	logic [AW-1:0] link_rd;

	logic          rd_en, wr_en, val_we;
	logic [AW-1:0] rd_addr, wr_addr, wr_data;
	logic          pos_ok;
	logic          is_ins;

	// stray link values read as the free head
	function automatic logic [AW-1:0] clamp_link(input logic [AW-1:0] v);
		if ({1'b0, v} >= (AW+1)'(DEPTH))
			return '0;
		return v;
	endfunction

	assign link_rd = clamp_link(rdata_q);
	assign is_ins = (req_q.op == OP_INSERT);

	always_comb begin
		logic [CMPW-1:0] pos_e, cnt_e;
		pos_e = CMPW'(req_q.position);
		cnt_e = CMPW'(count_q);
		if (is_ins)
			pos_ok = (pos_e != '0) && (pos_e <= cnt_e + CMPW'(1));
		else
			pos_ok = (pos_e != '0) && (pos_e <= cnt_e);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (clr_idx_q == HEAD) state_d = S_IDLE;
			S_IDLE:     if (start) state_d = S_CHECK;
			S_CHECK: begin
				if (!pos_ok) state_d = S_DONE;
				else if (is_ins) state_d = S_INS_FREE;
				else state_d = S_WALK;
			end
			S_INS_FREE: state_d = (link_rd == FREE) ? S_DONE : S_INS_POP;
			S_INS_POP:  state_d = S_WALK;
			S_WALK: begin
				if (steps_q == '0) state_d = is_ins ? S_INS_LINK : S_DEL_VIC;
			end
			S_INS_LINK: state_d = S_DONE;
			S_DEL_VIC:  state_d = (victim_q == FREE) ? S_DONE : S_DEL_FREE;
			S_DEL_FREE: state_d = S_DEL_PUSH;
			S_DEL_PUSH: state_d = S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory control and strobes
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = FREE;
		wr_en   = 1'b0;
		wr_addr = FREE;
		wr_data = FREE;
		val_we  = 1'b0;
		done    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = (clr_idx_q < LAST_FREE) ? clr_idx_q + AW'(1) : FREE;
			end
			S_CHECK: begin
				if (pos_ok) begin
					rd_en   = 1'b1;
					rd_addr = is_ins ? FREE : HEAD;
				end
			end
			S_INS_FREE: begin
				if (link_rd != FREE) begin
					rd_en   = 1'b1;
					rd_addr = link_rd;
				end
			end
			S_INS_POP: begin
				// unhook the taken slot from the free chain, store its value and start the walk
				wr_en   = 1'b1;
				wr_addr = FREE;
				wr_data = link_rd;
				val_we  = 1'b1;
				rd_en   = 1'b1;
				rd_addr = HEAD;
			end
			S_WALK: begin
				if (steps_q != '0 || !is_ins) begin
					rd_en   = 1'b1;
					rd_addr = link_rd;
				end else begin
					wr_en   = 1'b1;
					wr_addr = slot_q;
					wr_data = link_rd;
				end
			end
			S_INS_LINK: begin
				wr_en   = 1'b1;
				wr_addr = pred_q;
				wr_data = slot_q;
			end
			S_DEL_VIC: begin
				wr_en   = 1'b1;
				wr_addr = pred_q;
				wr_data = link_rd;
				if (victim_q != FREE) begin
					rd_en   = 1'b1;
					rd_addr = FREE;
				end
			end
			S_DEL_FREE: begin
				wr_en   = 1'b1;
				wr_addr = victim_q;
				wr_data = link_rd;
			end
			S_DEL_PUSH: begin
				wr_en   = 1'b1;
				wr_addr = FREE;
				wr_data = victim_q;
			end
			S_DONE:  done = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign rsp.ok = ok_q;
	assign rsp.length = 10'(count_q);

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= link_mem[rd_addr];
		if (wr_en)
			link_mem[wr_addr] <= wr_data;
		if (val_we)
			val_mem[slot_q] <= req_q.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			count_q   <= '0;
			clr_idx_q <= '0;
			ok_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: clr_idx_q <= clr_idx_q + AW'(1);
				S_CHECK: ok_q <= 1'b0;
				S_INS_LINK: begin
					count_q <= count_q + AW'(1);
					ok_q    <= 1'b1;
				end
				S_DEL_VIC: begin
					if (victim_q == FREE) begin
						count_q <= count_q - AW'(1);
						ok_q    <= 1'b1;
					end
				end
				S_DEL_PUSH: begin
					count_q <= count_q - AW'(1);
					ok_q    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// walk datapath: one link per cycle, counter decides when the predecessor is reached
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) req_q <= req;
			S_CHECK: begin
				cur_q   <= HEAD;
				steps_q <= req_q.position - 10'd1;
			end
			S_INS_FREE: slot_q <= link_rd;
			S_WALK: begin
				if (steps_q != '0) begin
					cur_q   <= link_rd;
					steps_q <= steps_q - 10'd1;
				end else begin
					pred_q   <= cur_q;
					victim_q <= link_rd;
				end
			end
			default: ;
		endcase
	end

	`ASSERT_AT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "accepted beat did not raise busy")
	`ASSERT_AT(a_single_done, clk, arst_n, done |=> !done, "result strobe longer than one cycle")
	`ASSERT_AT(a_count_max, clk, arst_n, count_q <= LAST_FREE, "element count above capacity")
	`ASSERT_NEVER(a_ins_ok_empty, clk, arst_n, done && rsp.ok && is_ins && count_q == '0, "successful insert left an empty list")

endmodule

/* sim/cursor_linked_list_tb.sv */
// self-checking testbench of the cursor linked list: directed table, then random list traffic
// depends on cll_pkg and cursor_linked_list; keeps its own copy of the link store as predictor
`timescale 1ns / 1ps

module cursor_linked_list_tb;
	import cll_pkg::*;

	localparam int DEPTH          = 1024;
	localparam int FREE_HEAD      = 0;
	localparam int LIST_HEAD      = DEPTH - 1;
	localparam int GROW_LEN       = 200;
	localparam int WATCHDOG_LIMIT = 8000;

	typedef struct packed {
		req_t item;
		logic typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// predictor state: link word of every slot and the element count
	int       link_mem [DEPTH];
	int       list_len;
	rsp_t     expected_rsp_q [$];
	rsp_t     front_rsp;
	dir_row_t dir_rows [$];
	int       err_count = 0;
	int       stall_cycles = 0;
	bit       idle_on;

	cursor_linked_list #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic req_t list_op(input op_t op, input int pos, input logic [31:0] val);
		req_t item;
		item.op       = op;
		item.position = 10'(pos);
		item.value    = val;
		return item;
	endfunction

	function automatic dir_row_t dir_row(input req_t item, input bit typed, input bit ok,
			input int len);
		dir_row_t row;
		row.item        = item;
		row.typed       = typed;
		row.want.ok     = ok;
		row.want.length = 10'(len);
		return row;
	endfunction

	function automatic rsp_t predict_list_op(input req_t item);
		rsp_t r;
		int slot;
		int pred;
		int victim;
		int n;
		r.ok = 1'b0;
		if (item.op == OP_INSERT) begin
			if (item.position >= 1 && item.position <= list_len + 1) begin
				slot = link_mem[FREE_HEAD];
				if (slot != 0) begin
					link_mem[FREE_HEAD] = link_mem[slot];
					pred = LIST_HEAD;
					for (n = 1; n < item.position; n++)
						pred = link_mem[pred];
					link_mem[slot] = link_mem[pred];
					link_mem[pred] = slot;
					list_len++;
					r.ok = 1'b1;
				end
			end
		end else begin
			if (item.position >= 1 && item.position <= list_len) begin
				pred = LIST_HEAD;
				for (n = 1; n < item.position; n++)
					pred = link_mem[pred];
				victim = link_mem[pred];
				link_mem[pred] = link_mem[victim];
				if (victim != 0) begin
					link_mem[victim]    = link_mem[FREE_HEAD];
					link_mem[FREE_HEAD] = victim;
				end
				list_len--;
				r.ok = 1'b1;
			end
		end
		r.length = list_len[9:0];
		return r;
	endfunction

	// mostly well-formed inserts and deletes, some noise and beats just past either end
	function automatic req_t rand_list_op(input int max_len);
		req_t item;
		int pick;
		item.value = $urandom;
		pick = $urandom_range(99);
		if (pick < 8) begin
			item.op       = op_t'($urandom_range(1));
			item.position = 10'($urandom_range(1023));
		end else if (pick < 14) begin
			item.op = op_t'($urandom_range(1));
			if ($urandom_range(3) == 0)
				item.position = '0;
			else if (item.op == OP_INSERT)
				item.position = 10'(list_len + 2);
			else
				item.position = 10'(list_len + 1);
		end else if (list_len == 0 || (list_len < max_len && $urandom_range(99) < 55)) begin
			item.op       = OP_INSERT;
			item.position = 10'($urandom_range(list_len + 1, 1));
		end else begin
			item.op       = OP_DELETE;
			item.position = 10'($urandom_range(list_len, 1));
		end
		return item;
	endfunction

	task automatic send_beat(input req_t item, input bit typed, input rsp_t want);
		rsp_t pred;
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// beat taken at this edge
		pred = predict_list_op(item);
		if (typed)
			pred = want;
		expected_rsp_q.push_back(pred);
		if (idle_on && $urandom_range(99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(12, 1))
				@(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual ok=%0b length=%0d",
					$time, rsp.ok, rsp.length);
				err_count++;
			end else begin
				front_rsp = expected_rsp_q.pop_front();
				if (rsp.ok !== front_rsp.ok) begin
					$display("%0t: ok mismatch, expected %0b actual %0b",
						$time, front_rsp.ok, rsp.ok);
					err_count++;
				end
				if (rsp.length !== front_rsp.length) begin
					$display("%0t: length mismatch, expected %0d actual %0d",
						$time, front_rsp.length, rsp.length);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles", $time, stall_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		idle_on      = 1'b1;
		for (i = 0; i < DEPTH - 2; i++)
			link_mem[i] = i + 1;
		link_mem[DEPTH - 2] = 0;
		link_mem[LIST_HEAD] = 0;
		list_len = 0;

		// empty list, position zero, past the end, extremes of position and value
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'h0000_0000), 1, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 0, 32'h1234_5678), 1, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 2, 32'h0000_0001), 1, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 1023, 32'hffff_ffff), 1, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 1, 32'h7fff_ffff), 1, 1, 1));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 0, 32'h8000_0000), 1, 0, 1));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 0, 32'h0000_0000), 1, 0, 1));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1023, 32'hffff_ffff), 1, 0, 1));
		// append, head and middle inserts, an insert and a delete past the end
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 2, 32'h8000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 1, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 2, 32'hffff_ffff), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 6, 32'h5555_5555), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 5, 32'h5555_5555), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 6, 32'haaaa_aaaa), 0, 0, 0));
		// tail, middle and head deletes, an append, head deletes into an empty list, then an insert and a delete
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 5, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 2, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 3, 32'haaaa_aaaa), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'h0000_0000), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_INSERT, 1, 32'h0000_ffff), 0, 0, 0));
		dir_rows.push_back(dir_row(list_op(OP_DELETE, 1, 32'hdead_beef), 0, 0, 0));

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k])
			send_beat(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
		wait_results_drained();

		for (i = 0; i < 200; i++) begin
			send_beat(rand_list_op(24), 1'b0, '0);
			if ($urandom_range(99) < 2)
				wait_results_drained();
		end
		wait_results_drained();

		// long stretch with the sender never idling
		idle_on = 1'b0;
		for (i = 0; i < 120; i++)
			send_beat(rand_list_op(60), 1'b0, '0);
		idle_on = 1'b1;
		wait_results_drained();

		// grow a long list with cheap near-head inserts, then deep walks and beats past the end
		while (list_len < GROW_LEN)
			send_beat(list_op(OP_INSERT, $urandom_range((list_len < 2) ? list_len + 1 : 3, 1),
				$urandom), 1'b0, '0);
		send_beat(list_op(OP_INSERT, list_len + 1, $urandom), 1'b0, '0);
		send_beat(list_op(OP_INSERT, 1023, $urandom), 1'b0, '0);
		send_beat(list_op(OP_INSERT, 512, $urandom), 1'b0, '0);
		send_beat(list_op(OP_DELETE, 1023, $urandom), 1'b0, '0);
		send_beat(list_op(OP_DELETE, list_len, $urandom), 1'b0, '0);
		send_beat(list_op(OP_INSERT, list_len + 2, $urandom), 1'b0, '0);
		send_beat(list_op(OP_DELETE, list_len + 1, $urandom), 1'b0, '0);
		send_beat(list_op(OP_DELETE, 150, $urandom), 1'b0, '0);
		send_beat(list_op(OP_INSERT, 150, $urandom), 1'b0, '0);
		send_beat(list_op(OP_DELETE, 0, $urandom), 1'b0, '0);
		wait_results_drained();

		for (i = 0; i < 80; i++) begin
			send_beat(rand_list_op(24), 1'b0, '0);
			if ($urandom_range(99) < 2)
				wait_results_drained();
		end

		wait_results_drained();
		repeat (DEPTH + 16)
			@(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
